// File: hw/rtl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types and constants of the base and dimer counter.
// ----------------------------------------------------------------------------
package bdc_pkg;

   typedef enum logic [1:0] {
      CMD_FEED   = 2'd0,
      CMD_SINGLE = 2'd1,
      CMD_DIMER  = 2'd2,
      CMD_TOTAL  = 2'd3
   } bdc_cmd_type;

   // total selects for the totals read
   localparam logic [3:0] TOT_CHARS = 4'd0;
   localparam logic [3:0] TOT_PAIRS = 4'd1;

   localparam logic [7:0] CHAR_HDR  = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_LF   = 8'h0A;  // newline
   localparam logic [7:0] CHAR_GAP  = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_N    = 8'h4E;
   localparam logic [7:0] CHAR_Z    = 8'h5A;
   localparam logic [7:0] CASE_MASK = 8'hDF;

   localparam logic [3:0] CODE_GAP  = 4'd0;
   localparam logic [3:0] CODE_N    = 4'd15;

   // letter to symbol code, A to Z; 5'd16 marks a letter with no code
   localparam logic [4:0] LETTER_CODE [26] = '{
      5'd1,  5'd11, 5'd2,  5'd12, 5'd16, 5'd16, 5'd3,  5'd13, 5'd16,
      5'd16, 5'd5,  5'd16, 5'd6,  5'd15, 5'd16, 5'd16, 5'd16, 5'd7,
      5'd9,  5'd4,  5'd16, 5'd14, 5'd10, 5'd16, 5'd8,  5'd16
   };

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] char_in;
      logic [3:0] first_sym;
      logic [3:0] second_sym;
   } bdc_req_type;

   typedef struct packed {
      logic [31:0] count_value;
      logic        in_header;
   } bdc_rsp_type;

   typedef struct packed {
      logic hit;
      logic [3:0] code;
   } bdc_sym_type;

   // control of the beat between the tally stage and the result register
   typedef struct packed {
      logic valid;
      logic use_pair;
      logic pair_inc;
      logic in_header;
   } bdc_stage_type;

   function automatic bdc_sym_type bdc_sym_of(input logic [7:0] ch);
      bdc_sym_type res;
      logic [7:0]  folded;
      logic [4:0]  offs;
      logic [4:0]  code;
      res    = '{hit: 1'b0, code: CODE_GAP};
      folded = ch & CASE_MASK;
      offs   = 5'(folded - CHAR_A);
      code   = LETTER_CODE[(offs < 5'd26) ? offs : 5'd0];
      if (ch == CHAR_GAP) begin
         res.hit  = 1'b1;
         res.code = CODE_GAP;
      end else if (folded >= CHAR_A && folded <= CHAR_Z && !code[4]) begin
         res.hit  = 1'b1;
         res.code = code[3:0];
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/bdc_if.sv
// ----------------------------------------------------------------------------
// bdc_if
// Valid/ready channels of the counter: request beats and response beats.
// ----------------------------------------------------------------------------
interface bdc_req_if;
   import bdc_pkg::*;
   logic        valid;
   logic        ready;
   bdc_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bdc_rsp_if;
   import bdc_pkg::*;
   logic        valid;
   logic        ready;
   bdc_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/bdc_tally.sv
// ----------------------------------------------------------------------------
// bdc_tally
// Line and header tracking, symbol decode, single counts and totals.
// ----------------------------------------------------------------------------
module bdc_tally #(
   parameter int SYMBOLS    = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_valid,
   input  logic [1:0]                               in_cmd,
   input  logic [7:0]                               in_char,
   input  logic [3:0]                               in_first,
   input  logic [3:0]                               in_second,
   output logic [$clog2(SYMBOLS*SYMBOLS)-1:0]       pair_addr,
   output bdc_pkg::bdc_stage_type                   stage,
   output logic [COUNT_BITS-1:0]                    tally_value
);
   import bdc_pkg::*;

   localparam int SymBits  = $clog2(SYMBOLS);
   localparam int AddrBits = $clog2(SYMBOLS*SYMBOLS);
   localparam logic [4:0]          SymLimit = 5'(SYMBOLS);
   localparam logic [AddrBits-1:0] SymCount = AddrBits'(SYMBOLS);

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
      return (&x) ? x : x + 1'b1;
   endfunction

   logic [COUNT_BITS-1:0] single_ff [SYMBOLS];
   logic [COUNT_BITS-1:0] char_total_ff, char_total_in;
   logic [COUNT_BITS-1:0] pair_total_ff, pair_total_in;
   logic [SymBits-1:0]    prev_code_ff, prev_code_in;
   logic                  prev_valid_ff, prev_valid_in;
   logic                  line_start_ff, line_start_in;
   logic                  header_ff, header_in;
   bdc_stage_type         stage_ff, stage_in;
   logic [COUNT_BITS-1:0] value_ff, value_in;

   bdc_cmd_type           cmd;
   bdc_sym_type           sym;
   logic                  is_sym;
   logic                  hdr_eff;
   logic                  first_ok;
   logic                  second_ok;
   logic [SymBits-1:0]    sidx;
   logic [COUNT_BITS-1:0] single_rd;
   logic                  single_we;

   always_comb begin
      cmd       = bdc_cmd_type'(in_cmd);
      sym       = bdc_sym_of(in_char);
      is_sym    = sym.hit && ({1'b0, sym.code} < SymLimit);
      hdr_eff   = header_ff || (line_start_ff && in_char == CHAR_HDR);
      first_ok  = {1'b0, in_first} < SymLimit;
      second_ok = {1'b0, in_second} < SymLimit;
      sidx      = (cmd == CMD_FEED) ? sym.code[SymBits-1:0] : in_first[SymBits-1:0];
      single_rd = single_ff[sidx];
   end

   always_comb begin
      char_total_in = char_total_ff;
      pair_total_in = pair_total_ff;
      prev_code_in  = prev_code_ff;
      prev_valid_in = prev_valid_ff;
      line_start_in = line_start_ff;
      header_in     = header_ff;
      single_we     = 1'b0;
      value_in      = '0;
      pair_addr     = '0;
      stage_in      = '{valid: in_valid, use_pair: 1'b0, pair_inc: 1'b0,
                        in_header: header_ff};
      if (in_valid) begin
         case (cmd)
            CMD_FEED: begin
               if (in_char == CHAR_LF) begin
                  line_start_in = 1'b1;
                  header_in     = 1'b0;
               end else begin
                  line_start_in = 1'b0;
                  header_in     = hdr_eff;
                  if (!hdr_eff) begin
                     char_total_in = sat_inc(char_total_ff);
                     if (is_sym) begin
                        single_we      = 1'b1;
                        pair_total_in  = sat_inc(pair_total_ff);
                        stage_in.pair_inc = prev_valid_ff;
                        pair_addr      = AddrBits'(sym.code[SymBits-1:0]) * SymCount
                                         + AddrBits'(prev_code_ff);
                        prev_code_in   = sym.code[SymBits-1:0];
                        prev_valid_in  = 1'b1;
                     end else begin
                        prev_valid_in  = 1'b0;
                     end
                  end
               end
               stage_in.in_header = header_in;
            end
            CMD_SINGLE: begin
               if (first_ok) begin
                  value_in = single_rd;
               end
            end
            CMD_DIMER: begin
               if (first_ok && second_ok) begin
                  stage_in.use_pair = 1'b1;
                  pair_addr = AddrBits'(in_first[SymBits-1:0]) * SymCount
                              + AddrBits'(in_second[SymBits-1:0]);
               end
            end
            CMD_TOTAL: begin
               if (in_first == TOT_CHARS) begin
                  value_in = char_total_ff;
               end else if (in_first == TOT_PAIRS) begin
                  value_in = pair_total_ff;
               end
            end
            default: begin
               value_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SYMBOLS; i++) begin
            single_ff[i] <= '0;
         end
         char_total_ff <= '0;
         pair_total_ff <= '0;
         prev_code_ff  <= '0;
         prev_valid_ff <= 1'b0;
         line_start_ff <= 1'b1;
         header_ff     <= 1'b0;
         stage_ff      <= '0;
      end else if (adv) begin
         if (single_we) begin
            single_ff[sidx] <= sat_inc(single_rd);
         end
         char_total_ff <= char_total_in;
         pair_total_ff <= pair_total_in;
         prev_code_ff  <= prev_code_in;
         prev_valid_ff <= prev_valid_in;
         line_start_ff <= line_start_in;
         header_ff     <= header_in;
         stage_ff      <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         value_ff <= value_in;
      end
   end

   assign stage       = stage_ff;
   assign tally_value = value_ff;

`ifndef SYNTH
   // every symbol is also a counted character
   assert property (@(posedge clock) disable iff (reset)
      pair_total_ff <= char_total_ff)
      else $error("pair total ahead of character total");

   // a header only starts on the first byte of a line, newline clears it
   assert property (@(posedge clock) disable iff (reset)
      header_ff |-> !line_start_ff)
      else $error("header flag set at line start");
`endif

endmodule

// File: hw/rtl/bdc_dimer_ram.sv
// ----------------------------------------------------------------------------
// bdc_dimer_ram
// Dimer counter memory: registered read, saturating increment and write back,
// with per-entry valid bits and forwarding of the previous write.
// ----------------------------------------------------------------------------
module bdc_dimer_ram #(
   parameter int SYMBOLS    = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic [$clog2(SYMBOLS*SYMBOLS)-1:0] rd_addr,
   input  bdc_pkg::bdc_stage_type             stage,
   output logic [COUNT_BITS-1:0]              pair_value
);
   import bdc_pkg::*;

   localparam int Depth    = SYMBOLS * SYMBOLS;
   localparam int AddrBits = $clog2(Depth);

   logic [COUNT_BITS-1:0] pair_mem_ff [Depth];
   logic [Depth-1:0]      vbit_ff;
   logic [COUNT_BITS-1:0] rdata_ff;
   logic                  rvalid_ff;
   logic [AddrBits-1:0]   addr_ff;
   logic                  fw_valid_ff;
   logic [AddrBits-1:0]   fw_addr_ff;
   logic [COUNT_BITS-1:0] fw_data_ff;

   logic [COUNT_BITS-1:0] cur_val;
   logic [COUNT_BITS-1:0] inc_val;
   logic                  we;

   always_comb begin
      // last write lands in the same edge as this beat's read
      if (fw_valid_ff && fw_addr_ff == addr_ff) begin
         cur_val = fw_data_ff;
      end else if (rvalid_ff) begin
         cur_val = rdata_ff;
      end else begin
         cur_val = '0;
      end
      inc_val = (&cur_val) ? cur_val : cur_val + 1'b1;
      we      = adv && stage.valid && stage.pair_inc;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rdata_ff <= pair_mem_ff[rd_addr];
      end
      if (we) begin
         pair_mem_ff[addr_ff] <= inc_val;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         addr_ff    <= rd_addr;
         fw_addr_ff <= addr_ff;
         fw_data_ff <= inc_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vbit_ff     <= '0;
         rvalid_ff   <= 1'b0;
         fw_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            rvalid_ff   <= vbit_ff[rd_addr];
            fw_valid_ff <= we;
         end
         if (we) begin
            vbit_ff[addr_ff] <= 1'b1;
         end
      end
   end

   assign pair_value = cur_val;

`ifndef SYNTH
   // saturating increment never wraps to zero
   assert property (@(posedge clock) disable iff (reset)
      we |-> (inc_val != '0))
      else $error("dimer count wrapped");

   // a written entry is marked valid from then on
   assert property (@(posedge clock) disable iff (reset)
      we |=> vbit_ff[$past(addr_ff)])
      else $error("dimer entry not marked valid after write");

   // forwarding only ever follows a write
   assert property (@(posedge clock) disable iff (reset)
      $rose(fw_valid_ff) |-> $past(we))
      else $error("forwarding without a write");
`endif

endmodule

// File: hw/rtl/base_and_dimer_counter_core.sv
// ----------------------------------------------------------------------------
// base_and_dimer_counter_core: symbol and dimer counter for sequence text
// Request, tally and response registers; one beat per cycle unless rsp stalls.
// The dimer memory read-modify-write forwards its last write to keep that rate.
// Synchronous reset clears all counts at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module base_and_dimer_counter_core #(
   parameter int SYMBOLS    = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   bdc_req_if.sink   req_chan,
   bdc_rsp_if.source rsp_chan
);
   import bdc_pkg::*;

   localparam int AddrBits = $clog2(SYMBOLS*SYMBOLS);

   logic                  adv;
   logic                  req_valid_ff;
   bdc_req_type           req_ff;
   logic                  rsp_valid_ff;
   bdc_rsp_type           rsp_ff;

   logic [AddrBits-1:0]   pair_addr;
   bdc_stage_type         stage;
   logic [COUNT_BITS-1:0] tally_value;
   logic [COUNT_BITS-1:0] pair_value;
   logic [COUNT_BITS-1:0] count_sel;

   // whole pipe moves when the response register is free
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         req_valid_ff <= req_chan.valid;
         rsp_valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         req_ff <= req_chan.payload;
         rsp_ff <= '{count_value: 32'(count_sel), in_header: stage.in_header};
      end
   end

   bdc_tally #(
      .SYMBOLS    (SYMBOLS),
      .COUNT_BITS (COUNT_BITS)
   ) u_tally (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid_ff),
      .in_cmd      (req_ff.cmd),
      .in_char     (req_ff.char_in),
      .in_first    (req_ff.first_sym),
      .in_second   (req_ff.second_sym),
      .pair_addr   (pair_addr),
      .stage       (stage),
      .tally_value (tally_value)
   );

   bdc_dimer_ram #(
      .SYMBOLS    (SYMBOLS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dimer_ram (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .rd_addr    (pair_addr),
      .stage      (stage),
      .pair_value (pair_value)
   );

   assign count_sel = stage.use_pair ? pair_value : tally_value;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

// File: dv/base_and_dimer_counter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base_and_dimer_counter_core_test
// Feeds sequence text of header and symbol lines with read beats mixed in.
// Every response is checked against a tally kept in the bench itself.
// ----------------------------------------------------------------------------
module base_and_dimer_counter_core_test;
   import bdc_pkg::*;

   localparam int          SYMBOL_COUNT = 16;
   localparam int          TOTAL_ITEMS  = 1350;
   localparam int          TAIL_ITEMS   = 200;
   localparam int          DRAIN_EVERY  = 400;
   localparam int          CYCLE_LIMIT  = 500000;
   localparam logic [4:0]  NOT_A_SYMBOL = 5'd16;
   // letter of each symbol code, code 0 first
   localparam logic [8*SYMBOL_COUNT-1:0] ALPHABET = "-ACGTKMRYSWBDHVN";

   // symbol code of a byte, NOT_A_SYMBOL when it has none
   function automatic logic [4:0] code_of(input logic [7:0] ch);
      logic [7:0] upper;
      logic [4:0] found;
      upper = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
      found = NOT_A_SYMBOL;
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
         if (upper == ALPHABET[8*(SYMBOL_COUNT-1-i) +: 8]) begin
            found = 5'(i);
         end
      end
      return found;
   endfunction

   class count_ledger;
      bit [31:0]   single_tally [SYMBOL_COUNT];
      bit [31:0]   dimer_tally [SYMBOL_COUNT*SYMBOL_COUNT];
      bit [31:0]   char_tally;
      bit [31:0]   pair_tally;
      bit [3:0]    last_code;
      bit          last_ok;
      bit          line_start = 1'b1;
      bit          header_now;
      bdc_rsp_type expected_counts [$];
      int unsigned failures;

      function void bump(ref bit [31:0] tally);
         if (tally != '1) begin
            tally = tally + 1;
         end
      endfunction

      function void take_byte(input logic [7:0] ch);
         logic [4:0] code;
         code = code_of(ch);
         if (line_start && ch == CHAR_HDR) begin
            header_now = 1'b1;
         end
         if (ch == CHAR_LF) begin
            line_start = 1'b1;
            header_now = 1'b0;
         end else begin
            line_start = 1'b0;
            if (!header_now) begin
               bump(char_tally);
               if (code[4]) begin
                  last_ok = 1'b0;
               end else begin
                  bump(single_tally[code[3:0]]);
                  bump(pair_tally);
                  if (last_ok) begin
                     bump(dimer_tally[code[3:0]*SYMBOL_COUNT + last_code]);
                  end
                  last_code = code[3:0];
                  last_ok   = 1'b1;
               end
            end
         end
      endfunction

      function void note_request(input bdc_req_type beat);
         bdc_rsp_type want;
         want.count_value = '0;
         case (bdc_cmd_type'(beat.cmd))
            CMD_FEED:   take_byte(beat.char_in);
            CMD_SINGLE: want.count_value = single_tally[beat.first_sym];
            CMD_DIMER:
               want.count_value = dimer_tally[beat.first_sym*SYMBOL_COUNT + beat.second_sym];
            CMD_TOTAL: begin
               if (beat.first_sym == TOT_CHARS) begin
                  want.count_value = char_tally;
               end else if (beat.first_sym == TOT_PAIRS) begin
                  want.count_value = pair_tally;
               end
            end
            default: begin
               want.count_value = '0;
            end
         endcase
         want.in_header = header_now;
         expected_counts.push_back(want);
      endfunction

      function void check_response(input bdc_rsp_type got);
         bdc_rsp_type want;
         if (expected_counts.size() == 0) begin
            $error("response beat with nothing outstanding: count_value %0d in_header %0b",
                   got.count_value, got.in_header);
            failures++;
         end else begin
            want = expected_counts.pop_front();
            if (got.count_value !== want.count_value) begin
               $error("count_value: expected %0d, got %0d", want.count_value, got.count_value);
               failures++;
            end
            if (got.in_header !== want.in_header) begin
               $error("in_header: expected %0b, got %0b", want.in_header, got.in_header);
               failures++;
            end
         end
      endfunction

      function int outstanding();
         return expected_counts.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   bdc_req_if   req_chan ();
   bdc_rsp_if   rsp_chan ();
   count_ledger board = new;

   int unsigned sent_items;
   int unsigned cycles_run;
   int unsigned send_idle_pct = 10;
   int unsigned rsp_idle_pct = 10;
   int unsigned rsp_hold;
   bit          quiet_tail;

   base_and_dimer_counter_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("base_and_dimer_counter_core_test: FAIL");
         $finish;
      end
   end

   // requests are noted before responses are checked, both on sampled values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            board.note_request(req_chan.payload);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            board.check_response(rsp_chan.payload);
         end
      end
   end

   // response back-pressure in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_chan.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_hold = $urandom_range(0, 18);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_beat(input bdc_req_type beat);
      if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= beat;
      do @(posedge clock); while (!req_chan.ready);
      sent_items++;
   endtask

   task automatic feed_byte(input logic [7:0] ch);
      bdc_req_type beat;
      beat.cmd        = CMD_FEED;
      beat.char_in    = ch;
      beat.first_sym  = 4'($urandom_range(0, 15));
      beat.second_sym = 4'($urandom_range(0, 15));
      send_beat(beat);
   endtask

   task automatic read_count(input bdc_cmd_type op, input logic [3:0] sel_a,
                             input logic [3:0] sel_b);
      bdc_req_type beat;
      beat.cmd        = op;
      beat.char_in    = 8'($urandom_range(0, 255));
      beat.first_sym  = sel_a;
      beat.second_sym = sel_b;
      send_beat(beat);
   endtask

   // occasional read or fully random beat between text bytes
   task automatic maybe_read();
      bdc_req_type beat;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         beat = bdc_req_type'(18'($urandom_range(0, 32'h3FFFF)));
         send_beat(beat);
      end else if (pick < 12) begin
         read_count(CMD_SINGLE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 20) begin
         read_count(CMD_DIMER, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 24) begin
         read_count(CMD_TOTAL,
                    ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(0, 1)),
                    4'($urandom_range(0, 15)));
      end
   endtask

   function automatic logic [7:0] sequence_byte();
      logic [7:0] ch;
      if ($urandom_range(0, 99) < 85) begin
         ch = ALPHABET[8*$urandom_range(0, SYMBOL_COUNT-1) +: 8];
         if ($urandom_range(0, 1) == 1) begin
            ch = ch | 8'h20;  // lower case, leaves '-' alone
         end
      end else begin
         ch = 8'($urandom_range(0, 255));
      end
      return ch;
   endfunction

   // one header line (usually) and a few sequence lines
   task automatic random_record();
      int unsigned lines;
      int unsigned len;
      logic [7:0]  ch;
      if ($urandom_range(0, 3) != 0) begin
         feed_byte(CHAR_HDR);
         len = $urandom_range(0, 20);
         repeat (len) begin
            maybe_read();
            ch = 8'($urandom_range(0, 255));
            feed_byte((ch == CHAR_LF) ? CHAR_HDR : ch);
         end
         feed_byte(CHAR_LF);
      end
      lines = $urandom_range(1, 4);
      repeat (lines) begin
         len = $urandom_range(0, 30);
         repeat (len) begin
            maybe_read();
            feed_byte(sequence_byte());
         end
         // sometimes the line is left open so the next '>' lands mid-line
         if ($urandom_range(0, 9) != 0) begin
            feed_byte(CHAR_LF);
         end
      end
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      while (board.outstanding() != 0) @(negedge clock);
   endtask

   function automatic int unsigned idle_rate();
      int unsigned pick;
      pick = $urandom_range(0, 2);
      return (pick == 0) ? 0 : (pick == 1) ? 5 : 25;
   endfunction

   initial begin
      int unsigned next_drain;
      logic [4:0]  code_c;
      logic [4:0]  code_a;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: counts after reset, header skipping, case folding, gaps,
      // non-symbol bytes, dimers across a line end, totals
      read_count(CMD_TOTAL, TOT_CHARS, CODE_GAP);
      read_count(CMD_DIMER, CODE_N, CODE_N);
      feed_byte(CHAR_HDR);
      feed_byte("x");
      feed_byte(CHAR_LF);
      feed_byte("a");
      feed_byte("C");
      feed_byte(CHAR_GAP);
      feed_byte(CHAR_LF);
      feed_byte("n");
      feed_byte("e");
      feed_byte("g");
      feed_byte(CHAR_HDR);
      feed_byte(8'hFF);
      feed_byte(8'h0D);
      feed_byte("0");
      feed_byte("t");
      feed_byte(CHAR_GAP);
      feed_byte(CHAR_GAP);
      code_c = code_of("C");
      code_a = code_of(CHAR_A);
      read_count(CMD_SINGLE, CODE_GAP, CODE_N);
      read_count(CMD_SINGLE, CODE_N, CODE_GAP);
      read_count(CMD_DIMER, code_c[3:0], code_a[3:0]);
      read_count(CMD_DIMER, CODE_N, CODE_GAP);
      read_count(CMD_TOTAL, TOT_CHARS, CODE_N);
      read_count(CMD_TOTAL, TOT_PAIRS, CODE_N);
      read_count(CMD_TOTAL, 4'hF, CODE_GAP);

      next_drain = DRAIN_EVERY;
      while (sent_items < TOTAL_ITEMS) begin
         if (sent_items >= TOTAL_ITEMS - TAIL_ITEMS) begin
            quiet_tail = 1'b1;
         end
         if ($urandom_range(0, 5) == 0) begin
            send_idle_pct = idle_rate();
            rsp_idle_pct  = idle_rate();
         end
         random_record();
         if (sent_items >= next_drain) begin
            // hold the sender until every response is back
            req_chan.valid <= 1'b0;
            wait_for_drain();
            @(posedge clock);
            next_drain += DRAIN_EVERY;
         end
      end
      req_chan.valid <= 1'b0;
      wait_for_drain();
      repeat (10) @(posedge clock);
      if (board.failures == 0 && board.outstanding() == 0) begin
         $display("base_and_dimer_counter_core_test: PASS");
      end else begin
         $display("base_and_dimer_counter_core_test: FAIL");
      end
      $finish;
   end

endmodule
